>>> hdl/aging_page_replacement_defines.svh
// assertion macros for the aging page replacement block
`ifndef AGING_PAGE_REPLACEMENT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS
`define APR_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("apr check failed");
`define APR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apr check failed");
`else
`define APR_ASSERT_NEVER(label, expr)
`define APR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/apr_pkg.sv
package apr_pkg;

  localparam int PAGE_FIELD_W  = 16;
  localparam int FRAME_FIELD_W = 3;
  localparam int TALLY_W       = 32;
  localparam int CFG_W         = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } apr_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } apr_cmd_t;

  typedef struct packed {
    logic hit_now;
    logic single;
    logic scan_last;
    logic out_busy;
  } apr_sts_t;

endpackage

>>> hdl/apr_ctrl.sv
module apr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  apr_pkg::apr_sts_t sts,
  output apr_pkg::apr_cmd_t cmd
);
  import apr_pkg::*;

  apr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // hits and single-frame misses need no search
          if (sts.hit_now || sts.single) begin
            state_nxt = ST_COMMIT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/apr_datapath.sv
module apr_datapath #(
  parameter int FRAMES    = 8,
  parameter int AGE_BITS  = 32,
  parameter int PAGE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [apr_pkg::CFG_W-1:0]            cfg_frames_in_use,
  input  logic [apr_pkg::PAGE_FIELD_W-1:0]     in_page_number,
  input  apr_pkg::apr_cmd_t                    cmd,
  output apr_pkg::apr_sts_t                    sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_hit,
  output logic [apr_pkg::FRAME_FIELD_W-1:0]    out_frame,
  output logic [apr_pkg::TALLY_W-1:0]          out_hits_total,
  output logic [apr_pkg::TALLY_W-1:0]          out_misses_total
);
  import apr_pkg::*;

  localparam int FIDX = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW   = $clog2(FRAMES + 1);
  // count register wide enough to hold FRAMES after reset
  localparam int RW   = (CW > CFG_W) ? CW : CFG_W;
  localparam int PW   = (PAGE_BITS > PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;
  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

  logic [RW-1:0]        cfg_r;
  logic [PAGE_BITS-1:0] tag_r [FRAMES];
  logic [FRAMES-1:0]    valid_r;
  logic [AGE_BITS-1:0]  age_r [FRAMES];
  logic [TALLY_W-1:0]   hit_tally_r, miss_tally_r;

  logic [PAGE_BITS-1:0] page_r;
  logic                 hit_r;
  logic [FIDX-1:0]      slot_r;
  logic [FIDX-1:0]      idx_r;
  logic [AGE_BITS-1:0]  best_r;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [FRAME_FIELD_W-1:0] out_frame_r;

  logic [CW-1:0]        n_act;
  logic [FRAMES-1:0]    active;
  logic [PW-1:0]        page_ext;
  logic [PAGE_BITS-1:0] page_in;
  logic [FRAMES-1:0]    match;
  logic                 hit_now;
  logic [FIDX-1:0]      hit_slot;
  logic [AGE_BITS-1:0]  val0, val_scan;
  logic [TALLY_W-1:0]   hit_tally_nxt, miss_tally_nxt;

  // effective frame count, clamped to 1..FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      n_act = CW'(1);
    end else if (int'(cfg_r) >= FRAMES) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(cfg_r);
    end
  end

  assign page_ext = PW'(in_page_number);
  assign page_in  = page_ext[PAGE_BITS-1:0];

  // parallel tag compare, lowest matching frame wins
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i < int'(n_act));
      match[i]  = active[i] && valid_r[i] && (tag_r[i] == page_in);
    end
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = FIDX'(i);
      end
    end
  end
  assign hit_now = |match;

  // empty frames count as age zero
  assign val0     = valid_r[0] ? age_r[0] : '0;
  assign val_scan = valid_r[idx_r] ? age_r[idx_r] : '0;

  assign hit_tally_nxt  = (hit_r && hit_tally_r != '1) ? hit_tally_r + 1'b1 : hit_tally_r;
  assign miss_tally_nxt = (!hit_r && miss_tally_r != '1) ? miss_tally_r + 1'b1 : miss_tally_r;

  assign sts.hit_now   = hit_now;
  assign sts.single    = (n_act == CW'(1));
  assign sts.scan_last = (CW'(idx_r) == n_act - CW'(1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= RW'(FRAMES);
    end else if (cfg_we) begin
      cfg_r <= RW'(cfg_frames_in_use);
    end
  end

  // working registers of the current transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= page_in;
      hit_r  <= hit_now;
      slot_r <= hit_now ? hit_slot : '0;
      best_r <= val0;
      idx_r  <= FIDX'(1);
    end else if (cmd.scan) begin
      if (val_scan < best_r) begin
        best_r <= val_scan;
        slot_r <= idx_r;
      end
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      hit_tally_r  <= '0;
      miss_tally_r <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        age_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      hit_tally_r  <= hit_tally_nxt;
      miss_tally_r <= miss_tally_nxt;
      if (!hit_r) begin
        valid_r[slot_r] <= 1'b1;
      end
      for (int i = 0; i < FRAMES; i++) begin
        if (active[i]) begin
          if (FIDX'(i) == slot_r) begin
            age_r[i] <= (hit_r ? (age_r[i] | AGE_TOP) : AGE_TOP) >> 1;
          end else begin
            age_r[i] <= age_r[i] >> 1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_r) begin
      tag_r[slot_r] <= page_r;
    end
  end

  // result register, frees the input side while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r   <= hit_r;
      out_frame_r <= FRAME_FIELD_W'(slot_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_frame        = out_frame_r;
  assign out_hits_total   = hit_tally_r;
  assign out_misses_total = miss_tally_r;

endmodule

>>> hdl/aging_page_replacement.sv
// Aging page replacement over up to FRAMES frames. Each input transfer carries one
// page reference; each one yields one result with hit/miss, the frame now holding the
// page and saturating hit and miss totals. Tags of all frames in use are compared in
// parallel at acceptance, so a hit needs no search. A miss walks the age counters
// through one comparator, one frame per cycle, to find the oldest frame (lowest index
// on ties, empty frames as age zero). A result that is not taken holds the block
// before its next update, while the next reference may already be accepted.
// frames_in_use must be written through the cfg port only while the block is idle,
// which it does not enforce; zero acts as one and values above FRAMES act as FRAMES.
`include "aging_page_replacement_defines.svh"

module aging_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int AGE_BITS  = 32,
  parameter int PAGE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [apr_pkg::CFG_W-1:0]         cfg_frames_in_use,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [apr_pkg::PAGE_FIELD_W-1:0]  in_page_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [apr_pkg::FRAME_FIELD_W-1:0] out_frame,
  output logic [apr_pkg::TALLY_W-1:0]       out_hits_total,
  output logic [apr_pkg::TALLY_W-1:0]       out_misses_total
);
  import apr_pkg::*;

  apr_cmd_t cmd_w;
  apr_sts_t sts_w;

  assign cfg_ready = 1'b1;

  apr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts_w),
    .cmd      (cmd_w)
  );

  apr_datapath #(
    .FRAMES    (FRAMES),
    .AGE_BITS  (AGE_BITS),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use),
    .in_page_number    (in_page_number),
    .cmd               (cmd_w),
    .sts               (sts_w),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_frame         (out_frame),
    .out_hits_total    (out_hits_total),
    .out_misses_total  (out_misses_total)
  );

  `APR_ASSERT_NEXT(a_commit_shows_result, cmd_w.commit, out_valid)
  `APR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `APR_ASSERT_NEVER(a_no_commit_over_waiting, cmd_w.commit && out_valid && !out_ready)

endmodule
